FILE: rtl/core/axis_rotation_moment_transfer_macros.svh
// Assertion macros used by the checker file of the rotation block.
// Needs no other file; include it by its bare name.
`ifndef AXIS_ROTATION_MOMENT_TRANSFER_MACROS_SVH
`define AXIS_ROTATION_MOMENT_TRANSFER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ARMT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rotation block assertion failed");

// Next-cycle implication, disabled while reset is held.
`define ARMT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rotation block assertion failed");

`endif

FILE: rtl/core/armt_pkg.sv
// Shared widths, constants, payload types and helper functions of the
// roll-axis rotation block. Depends on nothing.
package armt_pkg;

    localparam int FRAC_BITS_DEF      = 16;
    localparam int ROTATION_STEPS_DEF = 16;
    localparam int ATAN_ENTRIES       = 24;

    localparam int DATA_W   = 32;
    localparam int ANG_W    = 16;
    localparam int ANG_X_W  = ANG_W + 1;
    localparam int XY_W     = 32;
    localparam int Z_W      = 29;
    localparam int CS_FRAC  = 30;
    localparam int DEG_SHIFT = 14;
    localparam int PROD_W   = 2 * DATA_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int SAT_IN_W = SUM_W + 1;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);

    localparam logic signed [ANG_X_W-1:0] DEG360_Q6 = ANG_X_W'(23040);
    localparam logic signed [ANG_X_W-1:0] DEG180_Q6 = ANG_X_W'(11520);
    localparam logic signed [ANG_X_W-1:0] DEG90_Q6  = ANG_X_W'(5760);

    localparam logic signed [SAT_IN_W-1:0] SAT_MAX = {{(SAT_IN_W-DATA_W+1){1'b0}},
                                                      {(DATA_W-1){1'b1}}};
    localparam logic signed [SAT_IN_W-1:0] SAT_MIN = {{(SAT_IN_W-DATA_W+1){1'b1}},
                                                      {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
        logic signed [DATA_W-1:0] mx;
        logic signed [DATA_W-1:0] my;
        logic signed [DATA_W-1:0] mz;
        logic signed [DATA_W-1:0] wy;
    } t_payload;

    typedef struct packed {
        logic signed [XY_W-1:0] c;
        logic signed [XY_W-1:0] s;
    } t_trig;

    typedef struct packed {
        logic signed [DATA_W-1:0] disp_y;
        logic signed [DATA_W-1:0] disp_z;
        logic signed [DATA_W-1:0] moment_x;
        logic signed [DATA_W-1:0] moment_y;
        logic signed [DATA_W-1:0] moment_z;
        logic                     saturated;
    } t_result;

    // Arctangent of 2^-idx in degrees, scaled by 2^20.
    function automatic logic signed [Z_W-1:0] atan_deg(input int unsigned idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0:       v = Z_W'(47185920);
            1:       v = Z_W'(27855475);
            2:       v = Z_W'(14718068);
            3:       v = Z_W'(7471121);
            4:       v = Z_W'(3750058);
            5:       v = Z_W'(1876857);
            6:       v = Z_W'(938658);
            7:       v = Z_W'(469357);
            8:       v = Z_W'(234682);
            9:       v = Z_W'(117342);
            10:      v = Z_W'(58671);
            11:      v = Z_W'(29335);
            12:      v = Z_W'(14668);
            13:      v = Z_W'(7334);
            14:      v = Z_W'(3667);
            15:      v = Z_W'(1833);
            16:      v = Z_W'(917);
            17:      v = Z_W'(458);
            18:      v = Z_W'(229);
            19:      v = Z_W'(115);
            20:      v = Z_W'(57);
            21:      v = Z_W'(29);
            22:      v = Z_W'(14);
            23:      v = Z_W'(7);
            default: v = '0;
        endcase
        return v;
    endfunction

    // Clip to the signed 32-bit range; the top bit of the result flags a clip.
    function automatic logic [DATA_W:0] sat32(input logic signed [SAT_IN_W-1:0] v);
        logic [DATA_W:0] res;
        if (v > SAT_MAX) begin
            res = {1'b1, 1'b0, {(DATA_W-1){1'b1}}};
        end else if (v < SAT_MIN) begin
            res = {1'b1, 1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            res = {1'b0, v[DATA_W-1:0]};
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/axis_rotation_moment_transfer.sv
// Top level of the roll-axis rotation and moment transfer block.
// Depends on armt_pkg, armt_angle_prep, armt_cordic, armt_rotate_xfer, armt_out_buf.

// The block accepts one item per clock while ready and returns one result for each,
// in order. An item carries a roll angle (signed Q9.6 degrees, any 16-bit
// pattern, reduced modulo 360), a y/z displacement pair, an x/y/z moment
// triple and a wind-frame y displacement, all signed Q15.16. The displacement
// pair and the y/z moment pair are rotated by the angle, and the x moment gets
// the transfer term z * dl * wy, where dl is the misalignment register written
// through the configuration channel (reset value 0). Every result is rounded
// half up and clipped to 32 bits; o_saturated reports any clip, including a
// clip of the intermediate z * dl product. From input to output register there
// are two angle reduction stages, one CORDIC micro-rotation per stage, one
// sign stage, five multiply, round and saturate stages, and the output
// register. Throughput is one item per cycle while the output is not stalled.
// While the output is stalled, one more item leaves the pipeline into a skid
// stage and the input stays ready until that stage fills.
// Write the misalignment register only while no items are in flight.
module axis_rotation_moment_transfer #(
    parameter int FRAC_BITS      = armt_pkg::FRAC_BITS_DEF,
    parameter int ROTATION_STEPS = armt_pkg::ROTATION_STEPS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,

    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [armt_pkg::ANG_W-1:0]  i_roll_angle,
    input  logic signed [armt_pkg::DATA_W-1:0] i_disp_y_in,
    input  logic signed [armt_pkg::DATA_W-1:0] i_disp_z_in,
    input  logic signed [armt_pkg::DATA_W-1:0] i_moment_x_in,
    input  logic signed [armt_pkg::DATA_W-1:0] i_moment_y_in,
    input  logic signed [armt_pkg::DATA_W-1:0] i_moment_z_in,
    input  logic signed [armt_pkg::DATA_W-1:0] i_wind_disp_y,

    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [armt_pkg::DATA_W-1:0] o_disp_y_out,
    output logic signed [armt_pkg::DATA_W-1:0] o_disp_z_out,
    output logic signed [armt_pkg::DATA_W-1:0] o_moment_x_out,
    output logic signed [armt_pkg::DATA_W-1:0] o_moment_y_out,
    output logic signed [armt_pkg::DATA_W-1:0] o_moment_z_out,
    output logic                               o_saturated,

    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic signed [armt_pkg::DATA_W-1:0] i_misalignment_length
);

    logic signed [armt_pkg::DATA_W-1:0] r_misalign;

    logic                            pipe_en;
    armt_pkg::t_payload              in_pl;

    logic                            prep_vld, prep_neg;
    logic signed [armt_pkg::Z_W-1:0] prep_z;
    armt_pkg::t_payload              prep_pl;

    logic                            cord_vld;
    armt_pkg::t_trig                 cord_trig;
    armt_pkg::t_payload              cord_pl;

    logic                            rot_vld;
    armt_pkg::t_result               rot_res;
    armt_pkg::t_result               out_res;

    // The register is always ready; a write takes effect in the following cycle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_misalign <= '0;
        end else if (i_cfg_valid) begin
            r_misalign <= i_misalignment_length;
        end
    end

    // The whole pipeline shares one advance signal from the output buffer,
    // so valid bits and data move together and nothing is lost or repeated.
    assign o_in_ready = pipe_en;

    assign in_pl.y  = i_disp_y_in;
    assign in_pl.z  = i_disp_z_in;
    assign in_pl.mx = i_moment_x_in;
    assign in_pl.my = i_moment_y_in;
    assign in_pl.mz = i_moment_z_in;
    assign in_pl.wy = i_wind_disp_y;

    armt_angle_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_vld   (i_in_valid),
        .i_angle (i_roll_angle),
        .i_pl    (in_pl),
        .o_vld   (prep_vld),
        .o_z     (prep_z),
        .o_neg   (prep_neg),
        .o_pl    (prep_pl)
    );

    armt_cordic #(
        .STEPS (ROTATION_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_vld   (prep_vld),
        .i_z     (prep_z),
        .i_neg   (prep_neg),
        .i_pl    (prep_pl),
        .o_vld   (cord_vld),
        .o_trig  (cord_trig),
        .o_pl    (cord_pl)
    );

    armt_rotate_xfer #(
        .FRAC_BITS (FRAC_BITS)
    ) u_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_vld   (cord_vld),
        .i_trig  (cord_trig),
        .i_pl    (cord_pl),
        .i_dl    (r_misalign),
        .o_vld   (rot_vld),
        .o_res   (rot_res)
    );

    armt_out_buf u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (rot_vld),
        .i_res       (rot_res),
        .i_out_ready (i_out_ready),
        .o_en        (pipe_en),
        .o_vld       (o_out_valid),
        .o_res       (out_res)
    );

    assign o_disp_y_out   = out_res.disp_y;
    assign o_disp_z_out   = out_res.disp_z;
    assign o_moment_x_out = out_res.moment_x;
    assign o_moment_y_out = out_res.moment_y;
    assign o_moment_z_out = out_res.moment_z;
    assign o_saturated    = out_res.saturated;

endmodule

FILE: rtl/core/armt_angle_prep.sv
// Two pipeline stages that reduce the roll angle to [-90, 90] degrees and
// scale it to the CORDIC angle format. Depends on armt_pkg.
module armt_angle_prep (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_vld,
    input  logic signed [armt_pkg::ANG_W-1:0]   i_angle,
    input  armt_pkg::t_payload                  i_pl,
    output logic                                o_vld,
    output logic signed [armt_pkg::Z_W-1:0]     o_z,
    output logic                                o_neg,
    output armt_pkg::t_payload                  o_pl
);

    logic signed [armt_pkg::ANG_X_W-1:0] a0, a1, a2, a3, n_a;
    logic signed [armt_pkg::ANG_X_W-1:0] r_a;
    logic                                r1_vld;
    armt_pkg::t_payload                  r1_pl;

    logic signed [armt_pkg::ANG_X_W-1:0] a_fold;
    logic                                n_neg;
    logic signed [armt_pkg::Z_W-1:0]     n_z;
    logic signed [armt_pkg::Z_W-1:0]     r_z;
    logic                                r_neg;
    logic                                r2_vld;
    armt_pkg::t_payload                  r2_pl;

    // Stage 1: bring the angle into [-180, 180).
    always_comb begin
        a0  = armt_pkg::ANG_X_W'(i_angle);
        a1  = (a0 >= armt_pkg::DEG180_Q6) ? a0 - armt_pkg::DEG360_Q6 : a0;
        a2  = (a1 >= armt_pkg::DEG180_Q6) ? a1 - armt_pkg::DEG360_Q6 : a1;
        a3  = (a2 < -armt_pkg::DEG180_Q6) ? a2 + armt_pkg::DEG360_Q6 : a2;
        n_a = (a3 < -armt_pkg::DEG180_Q6) ? a3 + armt_pkg::DEG360_Q6 : a3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a   <= n_a;
            r1_pl <= i_pl;
        end
    end

    // Stage 2: fold beyond +/-90 degrees and remember to negate cos and sin.
    always_comb begin
        if (r_a > armt_pkg::DEG90_Q6) begin
            a_fold = r_a - armt_pkg::DEG180_Q6;
            n_neg  = 1'b1;
        end else if (r_a < -armt_pkg::DEG90_Q6) begin
            a_fold = r_a + armt_pkg::DEG180_Q6;
            n_neg  = 1'b1;
        end else begin
            a_fold = r_a;
            n_neg  = 1'b0;
        end
        n_z = armt_pkg::Z_W'(a_fold) <<< armt_pkg::DEG_SHIFT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (i_en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z   <= n_z;
            r_neg <= n_neg;
            r2_pl <= r1_pl;
        end
    end

    assign o_vld = r2_vld;
    assign o_z   = r_z;
    assign o_neg = r_neg;
    assign o_pl  = r2_pl;

endmodule

FILE: rtl/core/armt_cordic.sv
// Unrolled rotation-mode CORDIC, one micro-rotation per register stage,
// followed by a sign stage. Depends on armt_pkg.
module armt_cordic #(
    parameter int STEPS = armt_pkg::ROTATION_STEPS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_vld,
    input  logic signed [armt_pkg::Z_W-1:0] i_z,
    input  logic                            i_neg,
    input  armt_pkg::t_payload              i_pl,
    output logic                            o_vld,
    output armt_pkg::t_trig                 o_trig,
    output armt_pkg::t_payload              o_pl
);

    logic signed [armt_pkg::XY_W-1:0] w_x   [0:STEPS];
    logic signed [armt_pkg::XY_W-1:0] w_y   [0:STEPS];
    logic signed [armt_pkg::Z_W-1:0]  w_z   [0:STEPS];
    logic                             w_neg [0:STEPS];
    logic                             w_vld [0:STEPS];
    armt_pkg::t_payload               w_pl  [0:STEPS];

    logic                             r_vld;
    armt_pkg::t_trig                  r_trig;
    armt_pkg::t_payload               r_pl;

    assign w_x[0]   = armt_pkg::CORDIC_GAIN;
    assign w_y[0]   = '0;
    assign w_z[0]   = i_z;
    assign w_neg[0] = i_neg;
    assign w_vld[0] = i_vld;
    assign w_pl[0]  = i_pl;

    for (genvar i = 0; i < STEPS; i++) begin : g_stage
        logic signed [armt_pkg::XY_W-1:0] n_x, n_y, r_x, r_y;
        logic signed [armt_pkg::Z_W-1:0]  n_z, r_z;
        logic                             r_neg, r_svld;
        armt_pkg::t_payload               r_spl;

        // Rotate toward a zero residual angle; shifts round toward minus infinity.
        always_comb begin
            if (!w_z[i][armt_pkg::Z_W-1]) begin
                n_x = w_x[i] - (w_y[i] >>> i);
                n_y = w_y[i] + (w_x[i] >>> i);
                n_z = w_z[i] - armt_pkg::atan_deg(i);
            end else begin
                n_x = w_x[i] + (w_y[i] >>> i);
                n_y = w_y[i] - (w_x[i] >>> i);
                n_z = w_z[i] + armt_pkg::atan_deg(i);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_svld <= 1'b0;
            end else if (i_en) begin
                r_svld <= w_vld[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x   <= n_x;
                r_y   <= n_y;
                r_z   <= n_z;
                r_neg <= w_neg[i];
                r_spl <= w_pl[i];
            end
        end

        assign w_x[i+1]   = r_x;
        assign w_y[i+1]   = r_y;
        assign w_z[i+1]   = r_z;
        assign w_neg[i+1] = r_neg;
        assign w_vld[i+1] = r_svld;
        assign w_pl[i+1]  = r_spl;
    end

    // Sign stage: undo the 180 degree fold.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= w_vld[STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_trig.c <= w_neg[STEPS] ? -w_x[STEPS] : w_x[STEPS];
            r_trig.s <= w_neg[STEPS] ? -w_y[STEPS] : w_y[STEPS];
            r_pl     <= w_pl[STEPS];
        end
    end

    assign o_vld  = r_vld;
    assign o_trig = r_trig;
    assign o_pl   = r_pl;

endmodule

FILE: rtl/core/armt_rotate_xfer.sv
// Five pipeline stages of multiply, round and saturate: the four rotated
// values and the two-step x moment transfer. Depends on armt_pkg.
module armt_rotate_xfer #(
    parameter int FRAC_BITS = armt_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_vld,
    input  armt_pkg::t_trig                    i_trig,
    input  armt_pkg::t_payload                 i_pl,
    input  logic signed [armt_pkg::DATA_W-1:0] i_dl,
    output logic                               o_vld,
    output armt_pkg::t_result                  o_res
);

    localparam int DW = armt_pkg::DATA_W;
    localparam int PW = armt_pkg::PROD_W;
    localparam int SW = armt_pkg::SUM_W;
    localparam int QW = armt_pkg::SAT_IN_W;
    localparam int RW = SW - FRAC_BITS;
    localparam int MW = RW + 1;

    localparam logic signed [SW-1:0] ROUND_CS = SW'(1) <<< (armt_pkg::CS_FRAC - 1);
    localparam logic signed [SW-1:0] ROUND_F  = SW'(1) <<< (FRAC_BITS - 1);

    // Stage 1 registers: products.
    logic signed [PW-1:0] r1_yc, r1_zs, r1_zc, r1_ys;
    logic signed [PW-1:0] r1_myc, r1_mzs, r1_mzc, r1_mys, r1_zdl;
    logic signed [DW-1:0] r1_mx, r1_wy;
    logic                 r1_vld;

    // Stage 2 registers: rotated values and the clipped intermediate.
    logic signed [SW-1:0] sum_y, sum_z, sum_my, sum_mz, sum_t;
    logic [DW:0]          sat_y, sat_z, sat_my, sat_mz, sat_t;
    logic signed [DW-1:0] r2_dy, r2_dz, r2_my, r2_mz, r2_t, r2_mx, r2_wy;
    logic                 r2_flag, r2_vld;

    // Stage 3 registers: second transfer product.
    logic signed [PW-1:0] r3_tw;
    logic signed [DW-1:0] r3_dy, r3_dz, r3_my, r3_mz, r3_mx;
    logic                 r3_flag, r3_vld;

    // Stage 4 registers: rounded transfer term.
    logic signed [SW-1:0] sum_r;
    logic signed [RW-1:0] r4_r;
    logic signed [DW-1:0] r4_dy, r4_dz, r4_my, r4_mz, r4_mx;
    logic                 r4_flag, r4_vld;

    // Stage 5 registers: final x moment.
    logic signed [MW-1:0] sum_m;
    logic [DW:0]          sat_m;
    armt_pkg::t_result    r5_res;
    logic                 r5_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_yc  <= PW'(i_pl.y) * PW'(i_trig.c);
            r1_zs  <= PW'(i_pl.z) * PW'(i_trig.s);
            r1_zc  <= PW'(i_pl.z) * PW'(i_trig.c);
            r1_ys  <= PW'(i_pl.y) * PW'(i_trig.s);
            r1_myc <= PW'(i_pl.my) * PW'(i_trig.c);
            r1_mzs <= PW'(i_pl.mz) * PW'(i_trig.s);
            r1_mzc <= PW'(i_pl.mz) * PW'(i_trig.c);
            r1_mys <= PW'(i_pl.my) * PW'(i_trig.s);
            r1_zdl <= PW'(i_pl.z) * PW'(i_dl);
            r1_mx  <= i_pl.mx;
            r1_wy  <= i_pl.wy;
        end
    end

    always_comb begin
        sum_y  = SW'(r1_yc) + SW'(r1_zs) + ROUND_CS;
        sum_z  = SW'(r1_zc) - SW'(r1_ys) + ROUND_CS;
        sum_my = SW'(r1_myc) + SW'(r1_mzs) + ROUND_CS;
        sum_mz = SW'(r1_mzc) - SW'(r1_mys) + ROUND_CS;
        sum_t  = SW'(r1_zdl) + ROUND_F;
        sat_y  = armt_pkg::sat32(QW'(sum_y >>> armt_pkg::CS_FRAC));
        sat_z  = armt_pkg::sat32(QW'(sum_z >>> armt_pkg::CS_FRAC));
        sat_my = armt_pkg::sat32(QW'(sum_my >>> armt_pkg::CS_FRAC));
        sat_mz = armt_pkg::sat32(QW'(sum_mz >>> armt_pkg::CS_FRAC));
        sat_t  = armt_pkg::sat32(QW'(sum_t >>> FRAC_BITS));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_dy   <= sat_y[DW-1:0];
            r2_dz   <= sat_z[DW-1:0];
            r2_my   <= sat_my[DW-1:0];
            r2_mz   <= sat_mz[DW-1:0];
            r2_t    <= sat_t[DW-1:0];
            r2_flag <= sat_y[DW] | sat_z[DW] | sat_my[DW] | sat_mz[DW] | sat_t[DW];
            r2_mx   <= r1_mx;
            r2_wy   <= r1_wy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_tw   <= PW'(r2_t) * PW'(r2_wy);
            r3_dy   <= r2_dy;
            r3_dz   <= r2_dz;
            r3_my   <= r2_my;
            r3_mz   <= r2_mz;
            r3_mx   <= r2_mx;
            r3_flag <= r2_flag;
        end
    end

    assign sum_r = SW'(r3_tw) + ROUND_F;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_r    <= RW'(sum_r >>> FRAC_BITS);
            r4_dy   <= r3_dy;
            r4_dz   <= r3_dz;
            r4_my   <= r3_my;
            r4_mz   <= r3_mz;
            r4_mx   <= r3_mx;
            r4_flag <= r3_flag;
        end
    end

    always_comb begin
        sum_m = MW'(r4_r) + MW'(r4_mx);
        sat_m = armt_pkg::sat32(QW'(sum_m));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_res.disp_y    <= r4_dy;
            r5_res.disp_z    <= r4_dz;
            r5_res.moment_x  <= sat_m[DW-1:0];
            r5_res.moment_y  <= r4_my;
            r5_res.moment_z  <= r4_mz;
            r5_res.saturated <= r4_flag | sat_m[DW];
        end
    end

    assign o_vld = r5_vld;
    assign o_res = r5_res;

endmodule

FILE: rtl/core/armt_out_buf.sv
// Output register with a one-item skid stage between the pipeline and the
// result channel. Depends on armt_pkg.
module armt_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  armt_pkg::t_result i_res,
    input  logic              i_out_ready,
    output logic              o_en,
    output logic              o_vld,
    output armt_pkg::t_result o_res
);

    armt_pkg::t_result r_out, r_skid, n_out, n_skid;
    logic              r_out_vld, r_skid_vld, n_out_vld, n_skid_vld;

    // The pipeline moves only while the skid stage is empty; the item that
    // leaves it during an output stall lands in the skid stage.
    always_comb begin
        n_out      = r_out;
        n_skid     = r_skid;
        n_out_vld  = r_out_vld;
        n_skid_vld = r_skid_vld;
        if (r_skid_vld) begin
            if (i_out_ready) begin
                n_out      = r_skid;
                n_skid_vld = 1'b0;
            end
        end else if (!r_out_vld || i_out_ready) begin
            n_out     = i_res;
            n_out_vld = i_vld;
        end else if (i_vld) begin
            n_skid     = i_res;
            n_skid_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_en  = !r_skid_vld;
    assign o_vld = r_out_vld;
    assign o_res = r_out;

endmodule

FILE: rtl/core/armt_checker.sv
// Port-level checker of the rotation block and its bind to the top level.
// Depends on axis_rotation_moment_transfer_macros.svh and armt_pkg.
`include "axis_rotation_moment_transfer_macros.svh"

module armt_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               o_in_ready,
    input  logic                               o_out_valid,
    input  logic                               i_out_ready,
    input  logic signed [armt_pkg::DATA_W-1:0] o_disp_y_out,
    input  logic signed [armt_pkg::DATA_W-1:0] o_disp_z_out,
    input  logic signed [armt_pkg::DATA_W-1:0] o_moment_x_out,
    input  logic signed [armt_pkg::DATA_W-1:0] o_moment_y_out,
    input  logic signed [armt_pkg::DATA_W-1:0] o_moment_z_out,
    input  logic                               o_saturated
);

    localparam int OUT_W = 5 * armt_pkg::DATA_W + 1;

    logic [OUT_W-1:0] out_bits;
    logic             out_stall;
    logic             in_held;

    assign out_bits  = {o_disp_y_out, o_disp_z_out, o_moment_x_out, o_moment_y_out,
                        o_moment_z_out, o_saturated};
    assign out_stall = o_out_valid && !i_out_ready;
    assign in_held   = !o_in_ready;

    // A stalled result item holds its valid and its fields.
    `ARMT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid && $stable(out_bits))

    // The input is held off only when a result item is waiting at the output.
    `ARMT_ASSERT_NOW(a_ready_low_needs_out, i_clk, i_rst_n, in_held, o_out_valid)

    // Without an output stall the input stays ready.
    `ARMT_ASSERT_NEXT(a_ready_kept, i_clk, i_rst_n, o_in_ready && !out_stall, o_in_ready)

    // Once held off, the input stays held off until the output drains.
    `ARMT_ASSERT_NEXT(a_ready_held, i_clk, i_rst_n, in_held && !i_out_ready, in_held && o_out_valid)

endmodule

bind axis_rotation_moment_transfer armt_checker u_armt_checker (.*);
